// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside of reset.
`define CEB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every edge, reset included.
`define CEB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/ceb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ceb_pkg;

  localparam int ATTEMPT_W = 8;
  localparam int RANDOM_W  = 64;
  localparam int IN_W      = 72;
  localparam int MS_W      = 32;
  localparam int GROWTH_W  = 16;
  localparam int DIGIT_W   = 4;
  localparam int CFG_IDX_W = 2;

  localparam int DELAY_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 8;

  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROWTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_JITTER = 2'd3;

  localparam logic [MS_W-1:0]     BASE_RST   = 32'd100;
  localparam logic [GROWTH_W-1:0] GROWTH_RST = 16'd512;
  localparam logic [MS_W-1:0]     MAX_RST    = 32'd30000;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/capped_exponential_backoff_top.sv -----
// Retry delay generator: capped exponential backoff with optional full jitter.
// Input stream (s_*): one request per failed attempt, carrying the attempt
// number and a random word. Output stream (m_*): one delay in ms per request.
// Registers are written through wr_en / wr_index / wr_data; the user must
// write them only while no request is in flight, as the block does not
// enforce it: 0 base delay, 1 growth factor (Q8.8), 2 cap, 3 jitter enable.
// One request is worked on at a time; s_tready is high only while idle.
// Per request the growth factor is applied attempt-1 times, fewer if the
// early stop at the cap is reached; each step is one pass of the growth
// factor through a 4-bit digit-serial multiplier. Jitter adds a bit-serial
// remainder over the 64-bit random word. The result sits in an output
// register; a new request is taken while it waits. If the receiver stalls,
// a second finished result waits inside and no further request is accepted
// until the first one is taken.
// Synchronous reset clears the handshakes and loads the register defaults
// (base 100 ms, growth 2.0, cap 30000 ms, jitter off).
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module capped_exponential_backoff_top #(
  parameter int DELAY_WIDTH   = ceb_pkg::DELAY_WIDTH_DEF,
  parameter int FRACTION_BITS = ceb_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            wr_en,
  input  wire logic [ceb_pkg::CFG_IDX_W-1:0]   wr_index,
  input  wire logic [ceb_pkg::MS_W-1:0]        wr_data,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // [7:0] attempt_no, [71:8] random_word
  input  wire logic [ceb_pkg::IN_W-1:0]        s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [31:0] delay_ms
  output logic      [ceb_pkg::MS_W-1:0]        m_tdata
);

  localparam int D     = DELAY_WIDTH + FRACTION_BITS;
  localparam int MW    = ceb_pkg::MS_W;
  localparam int AW    = ceb_pkg::ATTEMPT_W;
  localparam int RW    = ceb_pkg::RANDOM_W;
  localparam int CMP_W = (D > MW + FRACTION_BITS) ? D : MW + FRACTION_BITS;
  localparam int RND_W = (DELAY_WIDTH > MW) ? DELAY_WIDTH : MW;
  localparam logic [D-1:0] DMAX = {D{1'b1}};
  localparam logic [D:0]   HALF = (D+1)'(1) << (FRACTION_BITS - 1);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_ROUND, S_CLAMP, S_MOD, S_OUT} state_t;

  logic [MW-1:0]                base_reg;
  logic [ceb_pkg::GROWTH_W-1:0] growth_reg;
  logic [MW-1:0]                max_reg;
  logic                         jit_reg;

  state_t                  state;
  logic [AW-1:0]           cnt;
  logic [D-1:0]            d;
  logic [RW-1:0]           rnd;
  logic [DELAY_WIDTH-1:0]  rounded;
  logic [MW-1:0]           delay;
  logic                    mul_start;
  logic                    mod_start;
  logic [MW:0]             mod_div;

  ceb_pkg::unit_stat_t     mul_stat;
  ceb_pkg::unit_stat_t     mod_stat;
  logic [D-1:0]            mul_prod;
  logic [MW-1:0]           mod_rem;

  logic [AW-1:0]           attempt;
  logic [AW-1:0]           cnt_init;
  logic [CMP_W-1:0]        base_q;
  logic [CMP_W-1:0]        cap_q;
  logic [D-1:0]            d_init;
  logic                    hit;
  logic [D:0]              sum;
  logic [DELAY_WIDTH:0]    sum_ms;
  logic [DELAY_WIDTH-1:0]  rounded_next;
  logic [RND_W-1:0]        rounded_ext;
  logic [MW-1:0]           clamp_next;
  logic                    out_load;

  assign attempt  = s_tdata[AW-1:0];
  assign cnt_init = (attempt == '0) ? '0 : attempt - 1'b1;
  assign base_q   = CMP_W'({base_reg, {FRACTION_BITS{1'b0}}});
  assign cap_q    = CMP_W'({max_reg, {FRACTION_BITS{1'b0}}});
  assign d_init   = (base_q > CMP_W'(DMAX)) ? DMAX : base_q[D-1:0];
  assign hit      = (CMP_W'(mul_prod) >= cap_q);

  assign sum          = {1'b0, d} + HALF;
  assign sum_ms       = sum[D:FRACTION_BITS];
  assign rounded_next = sum_ms[DELAY_WIDTH] ? {DELAY_WIDTH{1'b1}} : sum_ms[DELAY_WIDTH-1:0];
  assign rounded_ext  = RND_W'(rounded);
  assign clamp_next   = (rounded_ext > RND_W'(max_reg)) ? max_reg : rounded_ext[MW-1:0];
  assign out_load     = (state == S_OUT) && (!m_tvalid || m_tready);

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_reg   <= ceb_pkg::BASE_RST;
      growth_reg <= ceb_pkg::GROWTH_RST;
      max_reg    <= ceb_pkg::MAX_RST;
      jit_reg    <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        ceb_pkg::REG_BASE:   base_reg   <= wr_data;
        ceb_pkg::REG_GROWTH: growth_reg <= wr_data[ceb_pkg::GROWTH_W-1:0];
        ceb_pkg::REG_MAX:    max_reg    <= wr_data;
        ceb_pkg::REG_JITTER: jit_reg    <= wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      m_tvalid  <= 1'b0;
      mul_start <= 1'b0;
      mod_start <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      mod_start <= 1'b0;
      if (out_load) begin
        m_tdata  <= delay;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            d   <= d_init;
            cnt <= cnt_init;
            rnd <= s_tdata[AW +: RW];
            if (cnt_init == '0) begin
              state <= S_ROUND;
            end else begin
              mul_start <= 1'b1;
              state     <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (mul_stat.done) begin
            d   <= mul_prod;
            cnt <= cnt - 1'b1;
            if (hit || cnt == AW'(1)) begin
              state <= S_ROUND;
            end else begin
              mul_start <= 1'b1;
            end
          end
        end
        S_ROUND: begin
          rounded <= rounded_next;
          state   <= S_CLAMP;
        end
        S_CLAMP: begin
          delay <= clamp_next;
          if (jit_reg && clamp_next != '0) begin
            mod_div   <= {1'b0, clamp_next} + 1'b1;
            mod_start <= 1'b1;
            state     <= S_MOD;
          end else begin
            state <= S_OUT;
          end
        end
        S_MOD: begin
          if (mod_stat.done) begin
            delay <= mod_rem;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ceb_mul #(
    .DELAY_WIDTH   (DELAY_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .opnd_in (d),
    .growth  (growth_reg),
    .stat    (mul_stat),
    .prod    (mul_prod)
  );

  ceb_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (rnd),
    .divisor  (mod_div),
    .stat     (mod_stat),
    .rem      (mod_rem)
  );

  `CEB_ASSERT(a_one_in_flight, (s_tvalid && s_tready) |=> !s_tready, "request accepted while busy")
  `CEB_ASSERT(a_mul_free, mul_start |-> !mul_stat.busy, "multiplier restarted while busy")
  `CEB_ASSERT(a_mod_free, mod_start |-> !mod_stat.busy, "remainder restarted while busy")
  `CEB_ASSERT(a_mod_range, mod_stat.done |-> ({1'b0, mod_rem} < mod_div), "remainder not below divisor")
  `CEB_ASSERT_ALWAYS(a_reset_quiet, rst |=> !m_tvalid, "result valid after reset")

endmodule

`default_nettype wire

// ----- hw/rtl/ceb_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ceb_mul #(
  parameter int DELAY_WIDTH   = ceb_pkg::DELAY_WIDTH_DEF,
  parameter int FRACTION_BITS = ceb_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  input  wire logic [DELAY_WIDTH+FRACTION_BITS-1:0]   opnd_in,
  input  wire logic [ceb_pkg::GROWTH_W-1:0]           growth,
  output ceb_pkg::unit_stat_t                         stat,
  output logic      [DELAY_WIDTH+FRACTION_BITS-1:0]   prod
);

  localparam int D      = DELAY_WIDTH + FRACTION_BITS;
  localparam int GW     = ceb_pkg::GROWTH_W;
  localparam int DW     = ceb_pkg::DIGIT_W;
  localparam int PROD_W = D + GW;
  localparam int NDIG   = GW / DW;
  localparam int CNT_W  = $clog2(NDIG + 1);
  localparam logic [PROD_W-1:0] DMAX = {{(PROD_W-D){1'b0}}, {D{1'b1}}};

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mstate_t;

  mstate_t           state;
  logic [PROD_W-1:0] acc;
  logic [PROD_W-1:0] acc_next;
  logic [GW-1:0]     gsh;
  logic [D-1:0]      opnd;
  logic [CNT_W-1:0]  dig;
  logic [D+DW-1:0]   part;
  logic [PROD_W-1:0] shifted;
  logic              done;

  // one digit of the growth factor per cycle, most significant first
  assign part     = (D+DW)'(opnd) * (D+DW)'(gsh[GW-1 -: DW]);
  assign acc_next = (acc << DW) + PROD_W'(part);
  assign shifted  = acc >> FRACTION_BITS;

  assign stat.busy = (state != M_IDLE);
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (start) begin
            acc   <= '0;
            gsh   <= growth;
            opnd  <= opnd_in;
            dig   <= CNT_W'(NDIG);
            state <= M_RUN;
          end
        end
        M_RUN: begin
          acc <= acc_next;
          gsh <= gsh << DW;
          dig <= dig - 1'b1;
          if (dig == CNT_W'(1)) begin
            state <= M_FIN;
          end
        end
        M_FIN: begin
          // truncate the fraction, saturate the running delay
          prod  <= (shifted > DMAX) ? {D{1'b1}} : shifted[D-1:0];
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ceb_mod.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ceb_mod (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [ceb_pkg::RANDOM_W-1:0]  dividend,
  input  wire logic [ceb_pkg::MS_W:0]        divisor,
  output ceb_pkg::unit_stat_t                stat,
  output logic      [ceb_pkg::MS_W-1:0]      rem
);

  localparam int RW    = ceb_pkg::RANDOM_W;
  localparam int MW    = ceb_pkg::MS_W;
  localparam int CNT_W = $clog2(RW + 1);

  typedef enum logic {V_IDLE, V_RUN} vstate_t;

  vstate_t          state;
  logic [RW-1:0]    dvd;
  logic [MW:0]      div;
  logic [CNT_W-1:0] cnt;
  logic [MW:0]      trial;
  logic [MW:0]      diff;
  logic             done;

  // restoring remainder, one dividend bit per cycle
  assign trial = {rem, dvd[RW-1]};
  assign diff  = trial - div;

  assign stat.busy = (state != V_IDLE);
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= V_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        V_IDLE: begin
          if (start) begin
            dvd   <= dividend;
            div   <= divisor;
            rem   <= '0;
            cnt   <= CNT_W'(RW);
            state <= V_RUN;
          end
        end
        V_RUN: begin
          rem <= (trial >= div) ? diff[MW-1:0] : trial[MW-1:0];
          dvd <= dvd << 1;
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            done  <= 1'b1;
            state <= V_IDLE;
          end
        end
        default: state <= V_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- verif/backoff_checker.sv -----
`timescale 1ns / 1ps

module backoff_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [ceb_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [ceb_pkg::MS_W-1:0]      wr_data,
  input  wire logic                          s_tvalid,
  input  wire logic                          s_tready,
  input  wire logic [ceb_pkg::IN_W-1:0]      s_tdata,
  input  wire logic                          m_tvalid,
  input  wire logic                          m_tready,
  input  wire logic [ceb_pkg::MS_W-1:0]      m_tdata,
  output int                                 mismatches,
  output int                                 outstanding,
  output int                                 results_seen
);

  localparam int FRAC = ceb_pkg::FRACTION_BITS_DEF;
  localparam int Q_W  = ceb_pkg::DELAY_WIDTH_DEF + ceb_pkg::FRACTION_BITS_DEF;
  localparam logic [63:0] Q_LIMIT  = (64'd1 << Q_W) - 64'd1;
  localparam logic [63:0] MS_LIMIT = (64'd1 << ceb_pkg::DELAY_WIDTH_DEF) - 64'd1;

  logic [ceb_pkg::MS_W-1:0]     base_ms;
  logic [ceb_pkg::GROWTH_W-1:0] growth_q;
  logic [ceb_pkg::MS_W-1:0]     cap_ms;
  logic                         jitter_on;
  logic [ceb_pkg::MS_W-1:0]     expected_delays[$];
  logic [ceb_pkg::MS_W-1:0]     want;

  function automatic logic [ceb_pkg::MS_W-1:0] predict_retry_delay(
    input logic [ceb_pkg::ATTEMPT_W-1:0] attempt,
    input logic [ceb_pkg::RANDOM_W-1:0]  rnd
  );
    logic [63:0] d;
    logic [63:0] cap_q;
    logic [63:0] ms;
    logic [63:0] growth;
    int          steps;
    int          i;
    logic        capped;
    steps = (attempt == 0) ? 0 : int'(attempt) - 1;
    d = 64'(base_ms);
    d = d << FRAC;
    if (d > Q_LIMIT) d = Q_LIMIT;
    cap_q = 64'(cap_ms);
    cap_q = cap_q << FRAC;
    growth = 64'(growth_q);
    capped = 1'b0;
    for (i = 0; i < steps && !capped; i++) begin
      d = (d * growth) >> FRAC;
      if (d > Q_LIMIT) d = Q_LIMIT;
      capped = (d >= cap_q);
    end
    ms = (d + (64'd1 << (FRAC - 1))) >> FRAC;
    if (ms > MS_LIMIT) ms = MS_LIMIT;
    if (ms > 64'(cap_ms)) ms = 64'(cap_ms);
    if (jitter_on && ms != 0) ms = rnd % (ms + 64'd1);
    return ms[ceb_pkg::MS_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      base_ms   <= ceb_pkg::BASE_RST;
      growth_q  <= ceb_pkg::GROWTH_RST;
      cap_ms    <= ceb_pkg::MAX_RST;
      jitter_on <= 1'b0;
      expected_delays.delete();
      outstanding  <= 0;
      mismatches   = 0;
      results_seen = 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          ceb_pkg::REG_BASE:   base_ms   <= wr_data;
          ceb_pkg::REG_GROWTH: growth_q  <= wr_data[ceb_pkg::GROWTH_W-1:0];
          ceb_pkg::REG_MAX:    cap_ms    <= wr_data;
          ceb_pkg::REG_JITTER: jitter_on <= wr_data[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        expected_delays.push_back(
          predict_retry_delay(s_tdata[ceb_pkg::ATTEMPT_W-1:0],
                              s_tdata[ceb_pkg::IN_W-1:ceb_pkg::ATTEMPT_W]));
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_delays.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected delay_ms %0d with no request waiting", m_tdata);
          end
        end else begin
          want = expected_delays.pop_front();
          if (m_tdata !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("delay_ms mismatch on result %0d: expected %0d, got %0d",
                       results_seen, want, m_tdata);
            end
          end
        end
      end
      outstanding <= expected_delays.size();
    end
  end

endmodule

// ----- verif/capped_exponential_backoff_top_tb.sv -----
`timescale 1ns / 1ps

module capped_exponential_backoff_top_tb;

  logic                          clk      = 1'b0;
  logic                          rst      = 1'b1;
  logic                          wr_en    = 1'b0;
  logic [ceb_pkg::CFG_IDX_W-1:0] wr_index = '0;
  logic [ceb_pkg::MS_W-1:0]      wr_data  = '0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [ceb_pkg::IN_W-1:0]      s_tdata  = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [ceb_pkg::MS_W-1:0]      m_tdata;

  int mismatches;
  int outstanding;
  int results_seen;
  int send_idle_pct = 8;
  int recv_idle_pct = 84;
  int requests_sent = 0;
  int settings_used = 0;

  capped_exponential_backoff_top DUT (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  backoff_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #200000000;
    $display("capped_exponential_backoff_top_tb: FAIL");
    $finish;
  end

  task automatic push_request(input logic [ceb_pkg::ATTEMPT_W-1:0] attempt,
                              input logic [ceb_pkg::RANDOM_W-1:0] rnd);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rnd, attempt};
    do @(posedge clk); while (!s_tready);
    requests_sent++;
  endtask

  task automatic drain_requests();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic load_registers(input logic [ceb_pkg::MS_W-1:0] base,
                                input logic [ceb_pkg::GROWTH_W-1:0] growth,
                                input logic [ceb_pkg::MS_W-1:0] cap, input logic jitter);
    logic [31:0] junk;
    junk = $urandom;
    drain_requests();
    repeat (4) @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= ceb_pkg::REG_BASE;
    wr_data  <= base;
    @(posedge clk);
    wr_index <= ceb_pkg::REG_GROWTH;
    wr_data  <= {junk[31:16], growth};
    @(posedge clk);
    wr_index <= ceb_pkg::REG_MAX;
    wr_data  <= cap;
    @(posedge clk);
    wr_index <= ceb_pkg::REG_JITTER;
    wr_data  <= {junk[31:1], jitter};
    @(posedge clk);
    wr_en <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [ceb_pkg::MS_W-1:0] pick_ms();
    int kind;
    kind = $urandom_range(9);
    case (kind) inside
      0: return '0;
      1: return '1;
      [2:5]: return $urandom_range(100000, 1);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int                            phase;
    int                            n;
    int                            r;
    logic [ceb_pkg::ATTEMPT_W-1:0] att;
    logic [ceb_pkg::GROWTH_W-1:0]  growth_v;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    settings_used = 1;

    push_request(8'd0, '0);
    push_request(8'd1, '1);
    push_request(8'd2, {$urandom, $urandom});
    push_request(8'd10, {$urandom, $urandom});
    push_request(8'd255, '1);

    load_registers('1, '1, '1, 1'b0);
    push_request(8'd1, '0);
    push_request(8'd2, '1);
    push_request(8'd255, {$urandom, $urandom});

    // 1.5x growth from 1 ms: rounds 1.5 up to 2
    load_registers(32'd1, 16'd384, 32'd1000, 1'b0);
    push_request(8'd2, '0);
    push_request(8'd3, '0);

    load_registers(32'd50000, 16'd128, 32'd30000, 1'b1);
    push_request(8'd1, '0);
    push_request(8'd1, '1);
    push_request(8'd2, {$urandom, $urandom});

    load_registers(32'd100, 16'd0, 32'd500, 1'b1);
    push_request(8'd2, '1);
    push_request(8'd1, {$urandom, $urandom});

    load_registers(32'd7, 16'd512, 32'd0, 1'b1);
    push_request(8'd5, '1);

    load_registers('1, 16'd255, '1, 1'b1);
    push_request(8'd3, '1);

    for (phase = 0; phase < 15; phase++) begin
      case (phase / 5)
        0: begin
          send_idle_pct = 8;
          recv_idle_pct = 84;
        end
        1: begin
          send_idle_pct = 84;
          recv_idle_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (phase == 3) begin
        load_registers('1, '1, '1, 1'b1);
      end else if (phase == 8) begin
        load_registers('0, '0, '0, 1'b0);
      end else begin
        r = $urandom_range(7);
        case (r) inside
          0: growth_v = '0;
          1: growth_v = '1;
          2: growth_v = 16'd256;
          3: growth_v = 16'($urandom_range(255));
          [4:5]: growth_v = 16'($urandom_range(1024, 257));
          default: growth_v = 16'($urandom);
        endcase
        load_registers(pick_ms(), growth_v, pick_ms(), 1'($urandom_range(1)));
      end
      for (n = 0; n < 100; n++) begin
        r = $urandom_range(99);
        if (r < 80) begin
          att = 8'($urandom_range(16));
        end else if (r < 95) begin
          att = 8'($urandom_range(64));
        end else begin
          att = 8'($urandom_range(255));
        end
        push_request(att, {$urandom, $urandom});
        if ($urandom_range(49) == 0) begin
          drain_requests();
        end
      end
    end

    drain_requests();
    repeat (2000) @(posedge clk);

    $display("Covered %0d requests under %0d register settings; %0d delays compared,",
             requests_sent, settings_used, results_seen);
    $display("with sender-heavy, receiver-heavy and back-to-back handshake pacing.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("capped_exponential_backoff_top_tb: PASS");
    end else begin
      $display("capped_exponential_backoff_top_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/ceb_pkg.sv
hw/rtl/ceb_mul.sv
hw/rtl/ceb_mod.sv
hw/rtl/capped_exponential_backoff_top.sv
verif/backoff_checker.sv
verif/capped_exponential_backoff_top_tb.sv
